>>> sv/mfw_pkg.sv
// Shared types and fixed field widths for the median filter window core.
package mfw_pkg;

    localparam int PIX_W = 8;
    localparam int ROW_W = 12;
    localparam int COL_W = 10;
    localparam int CFG_W = 11;

    localparam logic [ROW_W-1:0] ROW_MAX     = 12'd4095;
    localparam logic [CFG_W-1:0] WIDTH_RESET = 11'd640;

    typedef logic [PIX_W-1:0] pixel_t;

    // Emission flag and window centre that travel alongside a word.
    typedef struct packed {
        logic             emit;
        logic [ROW_W-1:0] centre_row;
        logic [COL_W-1:0] centre_col;
    } meta_t;

endpackage

>>> sv/mfw_if.sv
// Valid/ready channel interfaces for the pixel input and the median result.
interface mfw_in_if;
    logic           valid;
    logic           ready;
    mfw_pkg::pixel_t pixel;
    logic           frame_start;

    modport source (output valid, output pixel, output frame_start, input ready);
    modport sink (input valid, input pixel, input frame_start, output ready);
endinterface

interface mfw_out_if;
    logic                        valid;
    logic                        ready;
    mfw_pkg::pixel_t             median_value;
    logic [mfw_pkg::ROW_W-1:0]   centre_row;
    logic [mfw_pkg::COL_W-1:0]   centre_col;

    modport source (output valid, output median_value, output centre_row,
                    output centre_col, input ready);
    modport sink (input valid, input median_value, input centre_row,
                  input centre_col, output ready);
endinterface

>>> sv/mfw_position.sv
// Image width register and raster position tracking with window emission decision.
module mfw_position #(
    parameter int WINDOW    = 5,
    parameter int MAX_WIDTH = 1024
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_wr_en,
    input  logic [mfw_pkg::CFG_W-1:0]   cfg_wr_data,
    input  logic                        accept,
    input  logic                        frame_start,
    output logic [$clog2(MAX_WIDTH)-1:0] col,
    output mfw_pkg::meta_t              meta
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int EW = (WW > mfw_pkg::CFG_W) ? WW : mfw_pkg::CFG_W;
    localparam int RW = mfw_pkg::ROW_W;

    logic [mfw_pkg::CFG_W-1:0] width_reg;
    logic [CW-1:0]             col_reg;
    logic [CW-1:0]             col_next;
    logic [RW-1:0]             row_reg;
    logic [RW-1:0]             row_next;
    logic [EW-1:0]             width_ext;
    logic [EW-1:0]             eff_w;
    logic [CW-1:0]             col_a;
    logic [CW-1:0]             col_b;
    logic [RW-1:0]             row_a;
    logic [RW-1:0]             row_b;
    logic [EW-1:0]             col_inc;

    function automatic logic [RW-1:0] row_sat_inc(input logic [RW-1:0] r);
        row_sat_inc = (r == mfw_pkg::ROW_MAX) ? r : r + RW'(1);
    endfunction

    always_comb
    begin
        width_ext = EW'(width_reg);
        if (width_ext < EW'(WINDOW))
        begin
            eff_w = EW'(WINDOW);
        end
        else if (width_ext > EW'(MAX_WIDTH))
        begin
            eff_w = EW'(MAX_WIDTH);
        end
        else
        begin
            eff_w = width_ext;
        end
    end

    always_comb
    begin
        col_a = frame_start ? '0 : col_reg;
        row_a = frame_start ? '0 : row_reg;

        // A column left beyond a width that shrank wraps to the next row.
        if (EW'(col_a) >= eff_w)
        begin
            col_b = '0;
            row_b = row_sat_inc(row_a);
        end
        else
        begin
            col_b = col_a;
            row_b = row_a;
        end

        col_inc = EW'(col_b) + EW'(1);
        if (col_inc >= eff_w)
        begin
            col_next = '0;
            row_next = row_sat_inc(row_b);
        end
        else
        begin
            col_next = col_inc[CW-1:0];
            row_next = row_b;
        end
    end

    assign col             = col_b;
    assign meta.emit       = (row_b >= RW'(WINDOW - 1)) && (col_b >= CW'(WINDOW - 1));
    assign meta.centre_row = row_b - RW'(WINDOW / 2);
    assign meta.centre_col = mfw_pkg::COL_W'(col_b - CW'(WINDOW / 2));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg <= mfw_pkg::WIDTH_RESET;
            col_reg   <= '0;
            row_reg   <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                width_reg <= cfg_wr_data;
            end
            if (accept)
            begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
        end
    end

endmodule

>>> sv/mfw_line_buf.sv
// Line buffer memory: one word per column holding the previous image rows.
module mfw_line_buf #(
    parameter int WORD_W = 32,
    parameter int DEPTH  = 1024
) (
    input  logic                     clk,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WORD_W-1:0]        rd_data,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WORD_W-1:0]        wr_data
);

    logic [WORD_W-1:0] mem [DEPTH];
    logic [WORD_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> sv/mfw_window.sv
// Sliding square window of pixels that shifts left by one column per word.
module mfw_window #(
    parameter int WINDOW = 5
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     shift_en,
    input  logic [WINDOW-1:0][mfw_pkg::PIX_W-1:0]    col_in,
    output logic [WINDOW*WINDOW*mfw_pkg::PIX_W-1:0]  window
);

    logic [WINDOW*WINDOW-1:0][mfw_pkg::PIX_W-1:0] win_reg;
    logic [WINDOW*WINDOW-1:0][mfw_pkg::PIX_W-1:0] win_next;

    always_comb
    begin
        for (int r = 0; r < WINDOW; r++)
        begin
            for (int c = 0; c < WINDOW - 1; c++)
            begin
                win_next[r*WINDOW + c] = win_reg[r*WINDOW + c + 1];
            end
            win_next[r*WINDOW + WINDOW - 1] = col_in[r];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg <= '0;
        end
        else if (shift_en)
        begin
            win_reg <= win_next;
        end
    end

    assign window = win_reg;

endmodule

>>> sv/mfw_median.sv
// Rank-based median selection in three register stages: compare, count, select.
module mfw_median #(
    parameter int N = 25
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          adv,
    input  logic                          in_valid,
    input  mfw_pkg::meta_t                in_meta,
    input  logic [N*mfw_pkg::PIX_W-1:0]   values,
    output logic                          out_valid,
    output mfw_pkg::pixel_t               out_median,
    output mfw_pkg::meta_t                out_meta
);

    localparam int M     = N / 2;
    localparam int CNT_W = $clog2(N + 1);

    logic [N-1:0][mfw_pkg::PIX_W-1:0] vals_in;
    logic [N-1:0][N-1:0]              lt;
    logic [N-1:0][N-1:0]              lt_reg;
    logic [N-1:0][N-1:0]              lt_t;
    logic [N-1:0][mfw_pkg::PIX_W-1:0] vals_a_reg;
    logic                             valid_a_reg;
    mfw_pkg::meta_t                   meta_a_reg;
    logic [N-1:0][CNT_W-1:0]          cnt_lt;
    logic [N-1:0][CNT_W-1:0]          cnt_gt;
    logic [N-1:0][CNT_W-1:0]          cnt_lt_reg;
    logic [N-1:0][CNT_W-1:0]          cnt_gt_reg;
    logic [N-1:0][mfw_pkg::PIX_W-1:0] vals_b_reg;
    logic                             valid_b_reg;
    mfw_pkg::meta_t                   meta_b_reg;
    mfw_pkg::pixel_t                  med;
    logic                             valid_c_reg;
    mfw_pkg::pixel_t                  med_reg;
    mfw_pkg::meta_t                   meta_c_reg;

    assign vals_in = values;

    // lt[i][j] is set when element j is strictly below element i.
    always_comb
    begin
        for (int i = 0; i < N; i++)
        begin
            for (int j = 0; j < N; j++)
            begin
                lt[i][j] = vals_in[j] < vals_in[i];
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < N; i++)
        begin
            for (int j = 0; j < N; j++)
            begin
                lt_t[i][j] = lt_reg[j][i];
            end
        end
        for (int i = 0; i < N; i++)
        begin
            cnt_lt[i] = CNT_W'($countones(lt_reg[i]));
            cnt_gt[i] = CNT_W'($countones(lt_t[i]));
        end
    end

    // An element is the median when at most M lie below it and fewer than N-M lie above.
    // All such elements carry the same value, so their OR is that value.
    always_comb
    begin
        med = '0;
        for (int i = 0; i < N; i++)
        begin
            if ((cnt_lt_reg[i] <= CNT_W'(M)) && (cnt_gt_reg[i] < CNT_W'(N - M)))
            begin
                med = med | vals_b_reg[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_a_reg <= 1'b0;
            valid_b_reg <= 1'b0;
            valid_c_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_a_reg <= in_valid;
            valid_b_reg <= valid_a_reg;
            valid_c_reg <= valid_b_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            lt_reg     <= lt;
            vals_a_reg <= vals_in;
            meta_a_reg <= in_meta;
            cnt_lt_reg <= cnt_lt;
            cnt_gt_reg <= cnt_gt;
            vals_b_reg <= vals_a_reg;
            meta_b_reg <= meta_a_reg;
            med_reg    <= med;
            meta_c_reg <= meta_b_reg;
        end
    end

    assign out_valid  = valid_c_reg;
    assign out_median = med_reg;
    assign out_meta   = meta_c_reg;

endmodule

>>> sv/median_filter_window_core.sv
// Streaming square-window median filter over a raster pixel stream.
// Throughput: one word per clock; a word is taken whenever the output register is free or drained.
// A result passes the line buffer read, window shift, compare, count and select registers
// in that order after its pixel word is accepted; the whole pipeline holds while the result waits.
// Reset clears position, window, pipeline valid flags and sets the image width to 640;
// the line buffer memory is not cleared and needs no clearing pass.
module median_filter_window_core #(
    parameter int WINDOW    = 5,
    parameter int MAX_WIDTH = 1024
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_wr_en,
    input  logic [mfw_pkg::CFG_W-1:0] cfg_wr_data,
    mfw_in_if.sink                    pixels,
    mfw_out_if.source                 results
);

    localparam int CW     = $clog2(MAX_WIDTH);
    localparam int PW     = mfw_pkg::PIX_W;
    localparam int LINES  = WINDOW - 1;
    localparam int WORD_W = PW * LINES;
    localparam int N      = WINDOW * WINDOW;

    logic                       adv;
    logic                       accept;
    logic [CW-1:0]              pos_col;
    mfw_pkg::meta_t             pos_meta;

    logic                       s1_valid_reg;
    mfw_pkg::pixel_t            s1_px_reg;
    logic [CW-1:0]              s1_col_reg;
    mfw_pkg::meta_t             s1_meta_reg;

    logic [WORD_W-1:0]          rd_data;
    logic [WORD_W-1:0]          rd_word;
    logic                       byp_reg;
    logic [WORD_W-1:0]          byp_data_reg;
    logic [WORD_W-1:0]          wr_data;
    logic                       shift_en;
    logic [WINDOW-1:0][PW-1:0]  col_in;
    logic [N*PW-1:0]            window;

    logic                       s2_valid_reg;
    mfw_pkg::meta_t             s2_meta_reg;

    logic                       med_valid;
    mfw_pkg::pixel_t            med_value;
    mfw_pkg::meta_t             med_meta;

    // The pipeline moves as a whole whenever the result register can take a new word.
    assign adv          = !med_valid || results.ready;
    assign pixels.ready = adv;
    assign accept       = pixels.valid && adv;
    assign shift_en     = adv && s1_valid_reg;

    mfw_position #(
        .WINDOW    (WINDOW),
        .MAX_WIDTH (MAX_WIDTH)
    ) u_position (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .accept      (accept),
        .frame_start (pixels.frame_start),
        .col         (pos_col),
        .meta        (pos_meta)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            byp_reg      <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= accept;
            s2_valid_reg <= s1_valid_reg && s1_meta_reg.emit;
            byp_reg      <= shift_en && (s1_col_reg == pos_col);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_px_reg    <= pixels.pixel;
            s1_col_reg   <= pos_col;
            s1_meta_reg  <= pos_meta;
            s2_meta_reg  <= s1_meta_reg;
            byp_data_reg <= wr_data;
        end
    end

    // A word that reads the column the previous word writes in the same cycle
    // takes the freshly written data instead of the stale memory contents.
    assign rd_word = byp_reg ? byp_data_reg : rd_data;

    // Lane 0 of a column word holds the row just above; each write ages the lanes by one.
    assign wr_data = {rd_word[PW*(LINES-1)-1:0], s1_px_reg};

    mfw_line_buf #(
        .WORD_W (WORD_W),
        .DEPTH  (MAX_WIDTH)
    ) u_line_buf (
        .clk     (clk),
        .rd_en   (adv),
        .rd_addr (pos_col),
        .rd_data (rd_data),
        .wr_en   (shift_en),
        .wr_addr (s1_col_reg),
        .wr_data (wr_data)
    );

    // New window column: oldest row at the top, current pixel at the bottom.
    assign col_in[WINDOW-1] = s1_px_reg;
    for (genvar r = 0; r < WINDOW - 1; r++)
    begin : g_col
        assign col_in[r] = rd_word[(WINDOW-2-r)*PW +: PW];
    end

    mfw_window #(
        .WINDOW (WINDOW)
    ) u_window (
        .clk      (clk),
        .rst_n    (rst_n),
        .shift_en (shift_en),
        .col_in   (col_in),
        .window   (window)
    );

    mfw_median #(
        .N (N)
    ) u_median (
        .clk        (clk),
        .rst_n      (rst_n),
        .adv        (adv),
        .in_valid   (s2_valid_reg),
        .in_meta    (s2_meta_reg),
        .values     (window),
        .out_valid  (med_valid),
        .out_median (med_value),
        .out_meta   (med_meta)
    );

    assign results.valid        = med_valid;
    assign results.median_value = med_value;
    assign results.centre_row   = med_meta.centre_row;
    assign results.centre_col   = med_meta.centre_col;

endmodule
